[rtl/dpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg
// Types, constants and the divide step shared by the pedestal tracker.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int ADC_W    = 14;
    localparam int IDX_W    = 19;
    localparam int PED_W    = 32;
    localparam int SQ_W     = 46;
    localparam int CNT_W    = 32;
    localparam int WIN_W    = 11;
    localparam int IMG_W    = 11;
    localparam int ENTRY_W  = PED_W + SQ_W + CNT_W;

    // long division of up to 46-bit sums by an 11-bit divisor
    localparam int DIV_STEP = 4;
    localparam int DIV_W    = 48;
    localparam int DIV_NST  = DIV_W / DIV_STEP;

    localparam logic [IMG_W-1:0] IMG_MAX      = '1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd128;

    // gain field codes
    localparam logic [1:0] GAIN_LOW  = 2'b00;
    localparam logic [1:0] GAIN_MID  = 2'b01;
    localparam logic [1:0] GAIN_HIGH = 2'b11;

    // expected_gain register codes
    typedef enum logic [1:0] {
        EXP_LOW      = 2'd0,
        EXP_MID      = 2'd1,
        EXP_HIGH     = 2'd2,
        EXP_DISABLED = 2'd3
    } exp_gain_t;

    // register index (paddr[2])
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_GAIN   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [15:0]      raw;
        logic             warm;
        logic             in_range;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               in_range;
        logic               en;
        logic               warm;
        logic               wrong;
        logic [PED_W-1:0]   ped;
        logic [SQ_W-1:0]    sq;
        logic [CNT_W-1:0]   cnt;
        logic [ADC_W-1:0]   adc;
        logic [2*ADC_W-1:0] x2;
        logic [WIN_W-1:0]   rem_p;
        logic [DIV_W-1:0]   n_p;
        logic [WIN_W-1:0]   rem_s;
        logic [DIV_W-1:0]   n_s;
    } stage_t;

    typedef struct packed {
        logic [WIN_W-1:0] rem;
        logic [DIV_W-1:0] n;
    } div_t;

    function automatic div_t div_bits(div_t s, logic [WIN_W-1:0] d);
        div_t           r;
        logic [WIN_W:0] t;
        r = s;
        for (int i = 0; i < DIV_STEP; i++) begin
            t   = {r.rem, r.n[DIV_W-1]};
            r.n = {r.n[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t      = t - {1'b0, d};
                r.n[0] = 1'b1;
            end
            r.rem = t[WIN_W-1:0];
        end
        return r;
    endfunction

    function automatic stage_t div_stage(stage_t s, logic [WIN_W-1:0] d);
        stage_t r;
        div_t   p;
        div_t   q;
        r       = s;
        p       = div_bits('{rem: s.rem_p, n: s.n_p}, d);
        q       = div_bits('{rem: s.rem_s, n: s.n_s}, d);
        r.rem_p = p.rem;
        r.n_p   = p.n;
        r.rem_s = q.rem;
        r.n_s   = q.n;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/detector_pedestal_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detector_pedestal_tracker
// Per-pixel pedestal, square-sum and wrong-gain tracking over a pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel request per cycle unless an output stall, a pixel hazard or
// the clearing pass holds it off, and returns one result per request, in
// order, through the RAM read, operand stage, twelve 4-bit stages of the S/W
// divider and the result register. Per-pixel state sits in one RAM of
// LINE_COUNT*COLUMN_COUNT entries; a request for a pixel that is still in the
// pipeline is held off until the earlier one has reached write-back. After
// reset the RAM is cleared, one entry a cycle, over all of its entries, during
// which no request is taken.
// ----------------------------------------------------------------------------
module detector_pedestal_tracker #(
    parameter int LINE_COUNT   = 512,
    parameter int COLUMN_COUNT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_raw_word,
    input  wire logic [18:0] s_pixel_index,
    input  wire logic        s_last_in_image,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [18:0]      m_out_pixel_index,
    output logic [31:0]      m_pedestal_sum,
    output logic [45:0]      m_square_sum,
    output logic [31:0]      m_wrong_gain_count,
    output logic             m_out_last_in_image
);

    localparam int DEPTH  = LINE_COUNT * COLUMN_COUNT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NST    = dpt_pkg::DIV_NST;
    localparam logic [dpt_pkg::IDX_W:0] PIX_LIMIT = (dpt_pkg::IDX_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // configuration
    logic [dpt_pkg::WIN_W-1:0] window_reg;
    logic [1:0]                exp_gain_reg;
    logic                      cfg_wr;
    logic [dpt_pkg::WIN_W-1:0] divisor;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= dpt_pkg::WINDOW_RESET;
            exp_gain_reg <= dpt_pkg::EXP_LOW;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dpt_pkg::REG_WINDOW: window_reg   <= pwdata[dpt_pkg::WIN_W-1:0];
                dpt_pkg::REG_GAIN:   exp_gain_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dpt_pkg::REG_WINDOW: prdata = {21'b0, window_reg};
            dpt_pkg::REG_GAIN:   prdata = {30'b0, exp_gain_reg};
            default:             prdata = '0;
        endcase
    end

    assign divisor = (window_reg == '0) ? dpt_pkg::WIN_W'(1) : window_reg;

    // clearing pass
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic                      adv;
    logic                      hazard;
    logic                      accept;
    logic                      a_valid_reg;
    dpt_pkg::req_t             a_reg;
    logic                      b_valid_reg;
    dpt_pkg::stage_t           b_reg;
    logic [NST-1:0]            d_valid_reg;
    dpt_pkg::stage_t           d_reg [NST];
    logic                      m_valid_reg;
    logic [dpt_pkg::IMG_W-1:0] images_reg;
    logic [dpt_pkg::IMG_W-1:0] images_next;

    assign adv    = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        hazard = (a_valid_reg && a_reg.idx == s_pixel_index)
              || (b_valid_reg && b_reg.idx == s_pixel_index);
        for (int k = 0; k < NST; k++) begin
            if (d_valid_reg[k] && d_reg[k].idx == s_pixel_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign s_ready = !clr_busy_reg && adv && !hazard;

    always_comb begin
        images_next = images_reg;
        if (accept && s_last_in_image && images_reg != dpt_pkg::IMG_MAX) begin
            images_next = images_reg + 1'b1;
        end
    end

    // state RAM
    logic [dpt_pkg::ENTRY_W-1:0] rdata;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [dpt_pkg::ENTRY_W-1:0] ram_wdata;
    logic                        wb_en;
    logic [dpt_pkg::ENTRY_W-1:0] wb_data;

    assign ram_we    = clr_busy_reg || wb_en;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : d_reg[NST-1].idx[ADDR_W-1:0];
    assign ram_wdata = clr_busy_reg ? '0 : wb_data;

    dpt_ram #(
        .WIDTH (dpt_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_pixel_index[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // operand stage
    dpt_pkg::stage_t b_next;
    logic [1:0]      want;

    always_comb begin
        unique case (exp_gain_reg)
            dpt_pkg::EXP_MID:  want = dpt_pkg::GAIN_MID;
            dpt_pkg::EXP_HIGH: want = dpt_pkg::GAIN_HIGH;
            default:           want = dpt_pkg::GAIN_LOW;
        endcase
        b_next.idx      = a_reg.idx;
        b_next.last     = a_reg.last;
        b_next.in_range = a_reg.in_range;
        b_next.en       = exp_gain_reg != dpt_pkg::EXP_DISABLED;
        b_next.warm     = a_reg.warm;
        b_next.wrong    = a_reg.raw[15:14] != want;
        b_next.ped      = rdata[dpt_pkg::PED_W-1:0];
        b_next.sq       = rdata[dpt_pkg::PED_W +: dpt_pkg::SQ_W];
        b_next.cnt      = rdata[dpt_pkg::PED_W + dpt_pkg::SQ_W +: dpt_pkg::CNT_W];
        b_next.adc      = a_reg.raw[dpt_pkg::ADC_W-1:0];
        b_next.x2       = a_reg.raw[dpt_pkg::ADC_W-1:0] * a_reg.raw[dpt_pkg::ADC_W-1:0];
        b_next.rem_p    = '0;
        b_next.n_p      = dpt_pkg::DIV_W'(rdata[dpt_pkg::PED_W-1:0]);
        b_next.rem_s    = '0;
        b_next.n_s      = dpt_pkg::DIV_W'(rdata[dpt_pkg::PED_W +: dpt_pkg::SQ_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            d_valid_reg <= '0;
            m_valid_reg <= 1'b0;
            images_reg  <= '0;
        end else begin
            images_reg <= images_next;
            if (adv) begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                d_valid_reg <= {d_valid_reg[NST-2:0], b_valid_reg};
                m_valid_reg <= d_valid_reg[NST-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg.idx      <= s_pixel_index;
            a_reg.last     <= s_last_in_image;
            a_reg.raw      <= s_raw_word;
            a_reg.warm     <= images_reg < window_reg;
            a_reg.in_range <= {1'b0, s_pixel_index} < PIX_LIMIT;
            b_reg          <= b_next;
            d_reg[0]       <= dpt_pkg::div_stage(b_reg, divisor);
            for (int k = 1; k < NST; k++) begin
                d_reg[k] <= dpt_pkg::div_stage(d_reg[k-1], divisor);
            end
        end
    end

    // update and write-back
    dpt_pkg::stage_t         f;
    logic [dpt_pkg::PED_W-1:0] base_p;
    logic [dpt_pkg::SQ_W-1:0]  base_s;
    logic [dpt_pkg::PED_W:0]   sum_p;
    logic [dpt_pkg::SQ_W:0]    sum_s;
    logic [dpt_pkg::PED_W-1:0] ped_new;
    logic [dpt_pkg::SQ_W-1:0]  sq_new;
    logic [dpt_pkg::CNT_W-1:0] cnt_new;
    logic                      upd;

    always_comb begin
        f      = d_reg[NST-1];
        upd    = f.en && (f.warm || !f.wrong);
        base_p = f.warm ? f.ped : f.ped - f.n_p[dpt_pkg::PED_W-1:0];
        base_s = f.warm ? f.sq : f.sq - f.n_s[dpt_pkg::SQ_W-1:0];
        sum_p  = {1'b0, base_p} + (dpt_pkg::PED_W + 1)'({f.adc, 8'b0});
        sum_s  = {1'b0, base_s} + (dpt_pkg::SQ_W + 1)'({f.x2, 8'b0});
        ped_new = f.ped;
        sq_new  = f.sq;
        if (upd) begin
            ped_new = sum_p[dpt_pkg::PED_W] ? '1 : sum_p[dpt_pkg::PED_W-1:0];
            sq_new  = sum_s[dpt_pkg::SQ_W] ? '1 : sum_s[dpt_pkg::SQ_W-1:0];
        end
        cnt_new = f.cnt;
        if (f.en && f.wrong && f.cnt != '1) begin
            cnt_new = f.cnt + 1'b1;
        end
        wb_data = {cnt_new, sq_new, ped_new};
        wb_en   = adv && d_valid_reg[NST-1] && f.in_range && f.en;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_out_pixel_index   <= f.idx;
            m_out_last_in_image <= f.last;
            m_pedestal_sum      <= f.in_range ? ped_new : '0;
            m_square_sum        <= f.in_range ? sq_new : '0;
            m_wrong_gain_count  <= f.in_range ? cnt_new : '0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

[rtl/dpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dpt_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
